@@ hdl/box_blur_3x3_edge_aware_unit_defines.svh @@
// Assertion helpers shared by the blur unit.
`ifndef BOX_BLUR_3X3_EDGE_AWARE_UNIT_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BB3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BB3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bb3_pkg.sv @@
package bb3_pkg;

    localparam int SUM_W      = 12;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int ROW_W      = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

    localparam int          WIDTH_RESET  = 640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;

    // floor(y/3) and floor(y/9) by reciprocal, exact for y below 2730
    localparam logic [11:0] DIV3_MUL   = 12'd2731;
    localparam int          DIV3_SHIFT = 13;
    localparam logic [11:0] DIV9_MUL   = 12'd1821;
    localparam int          DIV9_SHIFT = 14;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic has_l;
        logic has_r;
        logic has_t;
        logic has_b;
    } t_edges;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_sums;

    function automatic logic [11:0] div3(input logic [11:0] y);
        logic [24:0] p;
        p = 25'(y) * 25'(DIV3_MUL);
        return 12'(p >> DIV3_SHIFT);
    endfunction

    function automatic logic [11:0] div9(input logic [11:0] y);
        logic [24:0] p;
        p = 25'(y) * 25'(DIV9_MUL);
        return 12'(p >> DIV9_SHIFT);
    endfunction

    // (2*sum + n) / (2*n): mean rounded half up, n is 1, 2, 3, 4, 6 or 9
    function automatic logic [7:0] rounded_mean(input logic [SUM_W-1:0] sum,
                                                input logic [CNT_W-1:0] cnt);
        logic [12:0] x;
        logic [11:0] q;
        x = {sum, 1'b0} + 13'(cnt);
        unique case (cnt)
            4'd1:    q = x[12:1];
            4'd2:    q = 12'(x >> 2);
            4'd3:    q = div3(x[12:1]);
            4'd4:    q = 12'(x >> 3);
            4'd6:    q = div3(12'(x >> 2));
            4'd9:    q = div9(x[12:1]);
            default: q = x[12:1];
        endcase
        return q[7:0];
    endfunction

endpackage

@@ hdl/bb3_ctrl.sv @@
module bb3_ctrl
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  logic                  i_opcode,
    input  t_pixel                i_px,
    output logic                  o_enter,
    output t_pixel                o_px,
    output logic [$clog2(MAX_WIDTH)-1:0] o_addr,
    output logic                  o_emit,
    output t_edges                o_edges
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RST_W = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    logic [CW-1:0]    r_used_w;
    logic [15:0]      r_used_h;
    logic [AW-1:0]    r_in_col;
    logic [ROW_W-1:0] r_in_row;
    logic [AW-1:0]    r_out_col;
    logic [15:0]      r_out_row;

    logic [10:0] cfg_w;
    logic [CW-1:0] n_used_w;
    logic [15:0] n_used_h;
    logic done, ignore, col_last, last;

    assign cfg_w = i_cfg_data[10:0];

    always_comb begin
        priority if (cfg_w == 11'd0) begin
            n_used_w = CW'(1);
        end else if (32'(cfg_w) > MAX_WIDTH) begin
            n_used_w = CW'(MAX_WIDTH);
        end else begin
            n_used_w = CW'(cfg_w);
        end
        n_used_h = (i_cfg_data == 16'd0) ? 16'd1 : i_cfg_data;
    end

    // past the last input row every beat is a zero pixel outside the frame
    assign done     = r_in_row >= {1'b0, r_used_h};
    assign ignore   = !done && i_opcode;
    assign o_enter  = i_accept && !ignore;
    assign o_px     = done ? '0 : i_px;
    assign o_addr   = r_in_col;
    assign col_last = (CW'(r_in_col) + CW'(1)) >= r_used_w;
    assign o_emit   = (r_in_row >= ROW_W'(2)) || (r_in_row == ROW_W'(1) && r_in_col != '0);

    assign o_edges.has_l = r_out_col != '0;
    assign o_edges.has_r = (CW'(r_out_col) + CW'(1)) < r_used_w;
    assign o_edges.has_t = r_out_row != 16'd0;
    assign o_edges.has_b = ({1'b0, r_out_row} + 17'd1) < {1'b0, r_used_h};
    assign last          = !o_edges.has_b && !o_edges.has_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_w  <= CW'(RST_W);
            r_used_h  <= HEIGHT_RESET;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_cfg_valid && (i_cfg_index == CFG_IDX_WIDTH ||
                                     i_cfg_index == CFG_IDX_HEIGHT)) begin
            if (i_cfg_index == CFG_IDX_WIDTH) begin
                r_used_w <= n_used_w;
            end else begin
                r_used_h <= n_used_h;
            end
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (o_enter) begin
            if (o_emit && last) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (col_last) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + ROW_W'(1);
                end else begin
                    r_in_col <= r_in_col + AW'(1);
                end
                if (o_emit) begin
                    if (o_edges.has_r) begin
                        r_out_col <= r_out_col + AW'(1);
                    end else begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + 16'd1;
                    end
                end
            end
        end
    end

endmodule

@@ hdl/bb3_line_buf.sv @@
module bb3_line_buf
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_enter,
    input  t_pixel                       i_px,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_addr,
    input  logic                         i_emit,
    input  t_edges                       i_edges,
    input  logic                         i_adv,
    output logic                         o_valid,
    output t_pixel                       o_px,
    output logic                         o_emit,
    output t_edges                       o_edges,
    output t_pixel                       o_above,
    output t_pixel                       o_mid
);

    localparam int AW = $clog2(MAX_WIDTH);

    t_pixel mem_upper [0:MAX_WIDTH-1];
    t_pixel mem_middle [0:MAX_WIDTH-1];

    logic          r_valid;
    t_pixel        r_px;
    logic [AW-1:0] r_addr;
    logic          r_emit;
    t_edges        r_edges;
    t_pixel        r_rd_above;
    t_pixel        r_rd_mid;
    logic          r_fwd;
    t_pixel        r_fwd_above;
    t_pixel        r_fwd_mid;

    // a write and a read of one column in one cycle (one-pixel-wide frame)
    assign o_above = r_fwd ? r_fwd_above : r_rd_above;
    assign o_mid   = r_fwd ? r_fwd_mid : r_rd_mid;
    assign o_valid = r_valid;
    assign o_px    = r_px;
    assign o_emit  = r_emit;
    assign o_edges = r_edges;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            mem_upper[r_addr]  <= o_mid;
            mem_middle[r_addr] <= r_px;
        end
        if (i_enter) begin
            r_rd_above <= mem_upper[i_addr];
            r_rd_mid   <= mem_middle[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_enter) begin
            r_px        <= i_px;
            r_addr      <= i_addr;
            r_emit      <= i_emit;
            r_edges     <= i_edges;
            r_fwd_above <= o_mid;
            r_fwd_mid   <= r_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            if (i_enter) begin
                r_valid <= 1'b1;
                r_fwd   <= i_adv && (r_addr == i_addr);
            end else if (i_adv) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

@@ hdl/bb3_window.sv @@
module bb3_window
    import bb3_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_emit,
    input  t_edges           i_edges,
    input  t_pixel           i_px,
    input  t_pixel           i_above,
    input  t_pixel           i_mid,
    input  logic             i_take,
    output logic             o_valid,
    output t_sums            o_sums,
    output logic [CNT_W-1:0] o_count,
    output logic             o_last
);

    t_pixel r_win [0:2][0:2];
    logic   r_valid;
    t_edges r_edges;

    logic [2:0] row_on;
    logic [2:0] col_on;
    logic [8:0] sel;
    logic [9:0] row_red [0:2];
    logic [9:0] row_green [0:2];
    logic [9:0] row_blue [0:2];

    function automatic logic [9:0] part3(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c, input logic [2:0] on);
        return (on[0] ? 10'(a) : 10'd0) + (on[1] ? 10'(b) : 10'd0) +
               (on[2] ? 10'(c) : 10'd0);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= i_above;
            r_win[1][2] <= i_mid;
            r_win[2][2] <= i_px;
            r_edges     <= i_edges;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_emit;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // rows top..bottom, columns left..right of the output pixel
    assign row_on = {r_edges.has_b, 1'b1, r_edges.has_t};
    assign col_on = {r_edges.has_r, 1'b1, r_edges.has_l};

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sel[r*3 +: 3] = row_on[r] ? col_on : 3'b000;
            row_red[r]   = part3(r_win[r][0].red, r_win[r][1].red, r_win[r][2].red,
                                 sel[r*3 +: 3]);
            row_green[r] = part3(r_win[r][0].green, r_win[r][1].green, r_win[r][2].green,
                                 sel[r*3 +: 3]);
            row_blue[r]  = part3(r_win[r][0].blue, r_win[r][1].blue, r_win[r][2].blue,
                                 sel[r*3 +: 3]);
        end
    end

    assign o_sums.red   = SUM_W'(row_red[0]) + SUM_W'(row_red[1]) + SUM_W'(row_red[2]);
    assign o_sums.green = SUM_W'(row_green[0]) + SUM_W'(row_green[1]) +
                          SUM_W'(row_green[2]);
    assign o_sums.blue  = SUM_W'(row_blue[0]) + SUM_W'(row_blue[1]) + SUM_W'(row_blue[2]);
    assign o_count      = CNT_W'($countones(sel));
    assign o_last       = !r_edges.has_b && !r_edges.has_r;
    assign o_valid      = r_valid;

endmodule

@@ hdl/bb3_mean.sv @@
`include "box_blur_3x3_edge_aware_unit_defines.svh"

module bb3_mean
    import bb3_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_sums            i_sums,
    input  logic [CNT_W-1:0] i_count,
    input  logic             i_last,
    input  logic             i_out_stall,
    output logic             o_ready,
    output logic             o_out_valid,
    output t_pixel           o_px,
    output logic             o_last
);

    logic             r_c_valid;
    t_sums            r_c_sums;
    logic [CNT_W-1:0] r_c_cnt;
    logic             r_c_last;
    logic             r_out_valid;
    t_pixel           r_out_px;
    logic             r_out_last;

    logic out_free, c_move;
    t_pixel n_out_px;

    assign out_free = !r_out_valid || !i_out_stall;
    assign c_move   = r_c_valid && out_free;
    assign o_ready  = !r_c_valid || out_free;

    assign n_out_px.red   = rounded_mean(r_c_sums.red, r_c_cnt);
    assign n_out_px.green = rounded_mean(r_c_sums.green, r_c_cnt);
    assign n_out_px.blue  = rounded_mean(r_c_sums.blue, r_c_cnt);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_c_sums <= i_sums;
            r_c_cnt  <= i_count;
            r_c_last <= i_last;
        end
        if (c_move) begin
            r_out_px   <= n_out_px;
            r_out_last <= r_c_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_c_valid <= 1'b1;
            end else if (c_move) begin
                r_c_valid <= 1'b0;
            end
            if (c_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_px        = r_out_px;
    assign o_last      = r_out_last;

    `BB3_ASSERT_NOW(a_count_legal, i_clk, i_rst_n, r_c_valid, (r_c_cnt == 4'd1 || r_c_cnt == 4'd2 || r_c_cnt == 4'd3 || r_c_cnt == 4'd4 || r_c_cnt == 4'd6 || r_c_cnt == 4'd9), "neighbour count outside the legal set")
    `BB3_ASSERT_NOW(a_last_corner, i_clk, i_rst_n, r_c_valid && r_c_last, (r_c_cnt == 4'd1 || r_c_cnt == 4'd2 || r_c_cnt == 4'd4), "frame end word not at a bottom right corner")
    `BB3_ASSERT_NEXT(a_hold_pending, i_clk, i_rst_n, r_c_valid && r_out_valid && i_out_stall, r_c_valid, "pending word lost under output stall")

endmodule

@@ hdl/box_blur_3x3_edge_aware_unit.sv @@
// channel  | handshake                | payload
// ---------+--------------------------+----------------------------------------
// in       | i_in_valid / o_in_stall  | i_opcode, i_in_red, i_in_green, i_in_blue
// out      | o_out_valid / i_out_stall| o_out_red, o_out_green, o_out_blue, o_frame_end
// cfg      | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One word per clock sustained unless the output stalls; four register stages (line buffer
// read, window, sums, output) lie between the edge taking a trigger and its result.
// A blurred pixel trails its input by one row and one pixel; flush words drain the tail.
// Reset clears counters and stage valids; line buffers need no clearing pass.
// Output stall backs up through the stages; the input stalls only when all are full.
module box_blur_3x3_edge_aware_unit
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_opcode,
    input  logic [7:0]            i_in_red,
    input  logic [7:0]            i_in_green,
    input  logic [7:0]            i_in_blue,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_out_red,
    output logic [7:0]            o_out_green,
    output logic [7:0]            o_out_blue,
    output logic                  o_frame_end,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    t_pixel        in_px, ent_px, a_px, a_above, a_mid, out_px;
    logic [AW-1:0] ent_addr;
    logic          ent, ent_emit, a_valid, a_emit;
    t_edges        ent_edges, a_edges;
    logic          b_valid, c_ready;
    t_sums         b_sums;
    logic [CNT_W-1:0] b_count;
    logic          b_last;
    logic          a_free, b_free, a_move, b_move, accept;

    assign in_px.red   = i_in_red;
    assign in_px.green = i_in_green;
    assign in_px.blue  = i_in_blue;

    assign b_free     = !b_valid || c_ready;
    assign a_free     = !a_valid || b_free;
    assign a_move     = a_valid && b_free;
    assign b_move     = b_valid && c_ready;
    assign accept     = i_in_valid && a_free;
    assign o_in_stall = !a_free;
    assign o_cfg_ready = 1'b1;

    bb3_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_opcode    (i_opcode),
        .i_px        (in_px),
        .o_enter     (ent),
        .o_px        (ent_px),
        .o_addr      (ent_addr),
        .o_emit      (ent_emit),
        .o_edges     (ent_edges)
    );

    bb3_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_enter (ent),
        .i_px    (ent_px),
        .i_addr  (ent_addr),
        .i_emit  (ent_emit),
        .i_edges (ent_edges),
        .i_adv   (a_move),
        .o_valid (a_valid),
        .o_px    (a_px),
        .o_emit  (a_emit),
        .o_edges (a_edges),
        .o_above (a_above),
        .o_mid   (a_mid)
    );

    bb3_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (a_move),
        .i_emit  (a_emit),
        .i_edges (a_edges),
        .i_px    (a_px),
        .i_above (a_above),
        .i_mid   (a_mid),
        .i_take  (b_move),
        .o_valid (b_valid),
        .o_sums  (b_sums),
        .o_count (b_count),
        .o_last  (b_last)
    );

    bb3_mean u_mean (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (b_move),
        .i_sums      (b_sums),
        .i_count     (b_count),
        .i_last      (b_last),
        .i_out_stall (i_out_stall),
        .o_ready     (c_ready),
        .o_out_valid (o_out_valid),
        .o_px        (out_px),
        .o_last      (o_frame_end)
    );

    assign o_out_red   = out_px.red;
    assign o_out_green = out_px.green;
    assign o_out_blue  = out_px.blue;

endmodule
